// ===== rtl/lrast_pkg.sv =====
// Shared constants and types for the line rasterizer.
// No dependencies; imported by line_rasterizer_unit.
package lrast_pkg;

  // Default coordinate width and fixed field widths
  localparam int COORD_BITS_DEF = 16;
  localparam int CFG_W          = 13;
  localparam int CFG_IDX_W      = 2;
  localparam int OFS_W          = 26;

  // Register reset values
  localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_FOUR_CHANNELS = 2'd2
  } reg_idx_t;

  // Input word operation codes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

endpackage

// ===== rtl/line_rasterizer_unit.sv =====
// Bresenham line engine with frame clipping and frame buffer offset.
// Depends on lrast_pkg for widths, reset values and codes.
// The pixel word of a step is captured in stage one from the line state at the accepting
// edge, then moves to the output register once that register is free or not stalled.
// Throughput: one word per cycle while in_stall is low; loads and steps follow
// back to back, set by the single update of the line state. A load gives no output word.
// Reset (rst, synchronous) clears the active line and both pipeline stages
// and sets the frame to 640 x 480 with four channels.
module line_rasterizer_unit
  import lrast_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_write,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] x_end,
  input  logic signed [COORD_BITS-1:0] y_end,
  input  logic [7:0]                   red_in,
  input  logic [7:0]                   green_in,
  input  logic [7:0]                   blue_in,
  input  logic [7:0]                   alpha_in,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic [OFS_W-1:0]             byte_offset,
  output logic                         in_bounds,
  output logic [7:0]                   red_out,
  output logic [7:0]                   green_out,
  output logic [7:0]                   blue_out,
  output logic [7:0]                   alpha_out,
  output logic                         write_alpha,
  output logic                         last
);

  localparam int DW    = COORD_BITS + 1;
  localparam int DEC_W = COORD_BITS + 4;
  localparam int CMP_W = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;

  // configuration registers
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic             four_channels;

  // line state
  logic                         line_active;
  logic                         steep;
  logic signed [COORD_BITS-1:0] cur_x;
  logic signed [COORD_BITS-1:0] cur_y;
  logic signed [COORD_BITS-1:0] major_end;
  logic                         minor_dir_neg;
  logic [DW-1:0]                delta_major;
  logic [DW-1:0]                delta_minor;
  logic signed [DEC_W-1:0]      decision;
  logic [7:0]                   col_r, col_g, col_b, col_a;

  // first pipeline stage
  logic                         s1_valid;
  logic signed [COORD_BITS-1:0] s1_x;
  logic signed [COORD_BITS-1:0] s1_y;
  logic [OFS_W-1:0]             s1_prod;
  logic                         s1_inside;
  logic                         s1_last;
  logic [7:0]                   s1_r, s1_g, s1_b, s1_a;

  // handshake
  logic accept;
  logic s1_move;
  logic step_hit;

  assign s1_move  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_move;
  assign accept   = in_valid && !in_stall;
  assign step_hit = accept && (op == OP_STEP) && line_active;

  // load: deltas, octant choice and endpoint swap
  logic signed [DW-1:0]    dx, dy, md;
  logic [DW-1:0]           adx, ady;
  logic                    ld_steep, ld_swap;
  logic [DW-1:0]           ld_dmaj, ld_dmin;
  logic signed [DEC_W-1:0] ld_dec;

  always_comb begin
    dx       = DW'(x_end) - DW'(x_start);
    dy       = DW'(y_end) - DW'(y_start);
    adx      = dx[DW-1] ? $unsigned(-dx) : $unsigned(dx);
    ady      = dy[DW-1] ? $unsigned(-dy) : $unsigned(dy);
    ld_steep = !(ady < adx);
    ld_swap  = ld_steep ? (y_start > y_end) : (x_start > x_end);
    ld_dmaj  = ld_steep ? ady : adx;
    ld_dmin  = ld_steep ? adx : ady;
    md       = ld_steep ? dx : dy;
    ld_dec   = $signed(DEC_W'({ld_dmin, 1'b0})) - $signed(DEC_W'(ld_dmaj));
  end

  // step: clip test, row product, end test and advance
  logic                         st_inside;
  logic [OFS_W-1:0]             st_prod;
  logic                         st_last;
  logic signed [DEC_W-1:0]      dec_next;
  logic signed [COORD_BITS-1:0] minor_step;
  logic                         dec_pos;

  always_comb begin
    st_inside  = !cur_x[COORD_BITS-1] && !cur_y[COORD_BITS-1]
              && (CMP_W'($unsigned(cur_x)) < CMP_W'(image_width))
              && (CMP_W'($unsigned(cur_y)) < CMP_W'(image_height));
    st_prod    = OFS_W'($unsigned(cur_y)) * OFS_W'(image_width);
    st_last    = (steep ? cur_y : cur_x) == major_end;
    dec_pos    = !decision[DEC_W-1] && (decision != '0);
    minor_step = minor_dir_neg ? -COORD_BITS'(1) : COORD_BITS'(1);
    dec_next   = decision + $signed(DEC_W'({delta_minor, 1'b0}));
    if (dec_pos) begin
      dec_next = dec_next - $signed(DEC_W'({delta_major, 1'b0}));
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= WIDTH_RST;
      image_height  <= HEIGHT_RST;
      four_channels <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        REG_FOUR_CHANNELS: four_channels <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // line state: load replaces, step advances or ends the line
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (accept && (op == OP_LOAD)) begin
      line_active   <= 1'b1;
      steep         <= ld_steep;
      cur_x         <= ld_swap ? x_end : x_start;
      cur_y         <= ld_swap ? y_end : y_start;
      major_end     <= ld_steep ? (ld_swap ? y_start : y_end)
                                : (ld_swap ? x_start : x_end);
      minor_dir_neg <= (md != '0) && (md[DW-1] ^ ld_swap);
      delta_major   <= ld_dmaj;
      delta_minor   <= ld_dmin;
      decision      <= ld_dec;
      col_r         <= red_in;
      col_g         <= green_in;
      col_b         <= blue_in;
      col_a         <= alpha_in;
    end else if (step_hit) begin
      if (st_last) begin
        line_active <= 1'b0;
      end else begin
        decision <= dec_next;
        if (steep) begin
          cur_y <= cur_y + COORD_BITS'(1);
          if (dec_pos) begin
            cur_x <= cur_x + minor_step;
          end
        end else begin
          cur_x <= cur_x + COORD_BITS'(1);
          if (dec_pos) begin
            cur_y <= cur_y + minor_step;
          end
        end
      end
    end
  end

  // stage one: capture the current pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (step_hit) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_hit) begin
      s1_x      <= cur_x;
      s1_y      <= cur_y;
      s1_prod   <= st_prod;
      s1_inside <= st_inside;
      s1_last   <= st_last;
      s1_r      <= col_r;
      s1_g      <= col_g;
      s1_b      <= col_b;
      s1_a      <= col_a;
    end
  end

  // stage two: finish the byte offset
  logic [OFS_W-1:0] pix_index;
  logic [OFS_W-1:0] ofs_next;

  always_comb begin
    pix_index = OFS_W'($unsigned(s1_x)) + s1_prod;
    if (!s1_inside) begin
      ofs_next = '0;
    end else if (four_channels) begin
      ofs_next = {pix_index[OFS_W-3:0], 2'b00};
    end else begin
      ofs_next = {pix_index[OFS_W-2:0], 1'b0} + pix_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      pixel_x     <= s1_x;
      pixel_y     <= s1_y;
      byte_offset <= ofs_next;
      in_bounds   <= s1_inside;
      red_out     <= s1_r;
      green_out   <= s1_g;
      blue_out    <= s1_b;
      alpha_out   <= s1_a;
      write_alpha <= four_channels;
      last        <= s1_last;
    end
  end

  // checks
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled while the pipeline can drain");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (step_hit && st_last) |=> !line_active)
    else $error("line still active after its last pixel");

  a_clip_zero_offset: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !in_bounds) |-> (byte_offset == '0))
    else $error("nonzero offset on a clipped pixel");

  a_inside_nonneg: assert property (@(posedge clk) disable iff (rst)
    (out_valid && in_bounds) |-> (!pixel_x[COORD_BITS-1] && !pixel_y[COORD_BITS-1]))
    else $error("negative coordinate marked in bounds");

endmodule
